FILE: hdl/stanley_steering_law_assert.svh
// assertion macros used by the checker file
`ifndef STANLEY_STEERING_LAW_ASSERT_SVH
`define STANLEY_STEERING_LAW_ASSERT_SVH

// same-cycle implication, disabled during reset
`define STL_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stl assertion failed");

// next-cycle implication, disabled during reset
`define STL_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stl assertion failed");

`endif

FILE: hdl/stl_pkg.sv
// shared types, constants and the arctangent table of the steering law pipeline
`timescale 1ns / 1ps
package stl_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int ANGLE_TAB_SIZE    = 24;
    localparam int NITER = (CORDIC_ITERATIONS < ANGLE_TAB_SIZE) ?
                           CORDIC_ITERATIONS : ANGLE_TAB_SIZE;

    localparam int VW    = 52;   // cordic x/y datapath
    localparam int CW    = 46;   // companion vector datapath
    localparam int ZW    = 28;   // angle accumulator, q24
    localparam int OPW   = 48;   // operand width into the normalizer
    localparam int SHW   = 6;    // normalize shift amount
    localparam int TAG_W = 64;   // side data carried along the cordic
    localparam int NORM_MSB = 45;

    localparam logic signed [ZW-1:0] PI_Q24       = 28'sd52707179;
    localparam logic signed [20:0]   INV_GAIN_Q20 = 21'sd636752;

    typedef logic [0:0] cfg_addr_t;
    localparam cfg_addr_t REG_CROSSTRACK_GAIN = 1'b0;
    localparam cfg_addr_t REG_SOFTENING_SPEED = 1'b1;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] vehicle_x;
        logic signed [31:0] vehicle_y;
        logic signed [15:0] vehicle_heading;
        logic signed [15:0] speed;
    } in_item_t;

    typedef struct packed {
        logic signed [17:0] steering_angle;
        logic signed [31:0] crosstrack_error;
        logic signed [15:0] path_angle;
    } out_item_t;

    // one cordic stage worth of state
    typedef struct packed {
        logic                 valid;
        logic                 zero;
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [ZW-1:0] z;
        logic [TAG_W-1:0]     tag;
    } vec_t;

    // atan(2^-i) in q24
    function automatic logic signed [ZW-1:0] atan_q24(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0:  r = 28'sd13176795;
            1:  r = 28'sd7778716;
            2:  r = 28'sd4110060;
            3:  r = 28'sd2086331;
            4:  r = 28'sd1047214;
            5:  r = 28'sd524117;
            6:  r = 28'sd262123;
            7:  r = 28'sd131069;
            8:  r = 28'sd65536;
            9:  r = 28'sd32768;
            10: r = 28'sd16384;
            11: r = 28'sd8192;
            12: r = 28'sd4096;
            13: r = 28'sd2048;
            14: r = 28'sd1024;
            15: r = 28'sd512;
            16: r = 28'sd256;
            17: r = 28'sd128;
            18: r = 28'sd64;
            19: r = 28'sd32;
            20: r = 28'sd16;
            21: r = 28'sd8;
            22: r = 28'sd4;
            23: r = 28'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/stl_prenorm.sv
// three-stage normalizer and half-plane pre-rotation ahead of a cordic
`timescale 1ns / 1ps
module stl_prenorm
    import stl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid,
    input  logic signed [OPW-1:0] x,
    input  logic signed [OPW-1:0] y,
    input  logic signed [CW-1:0]  cx,
    input  logic signed [CW-1:0]  cy,
    input  logic [TAG_W-1:0]      tag,
    output vec_t                  vec
);

    logic                  v1_reg, v2_reg;
    logic signed [OPW-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [CW-1:0]  cx1_reg, cy1_reg, cx2_reg, cy2_reg;
    logic [TAG_W-1:0]      tag1_reg, tag2_reg;
    logic [OPW-1:0]        orm_reg;
    logic [SHW-1:0]        sh_reg;
    logic                  zero_reg;
    vec_t                  vec_reg;

    logic [OPW-1:0]        mx, my;
    logic [SHW-1:0]        msb, sh_next;
    logic signed [VW-1:0]  xs, ys;
    vec_t                  vec_next;

    // magnitudes; most negative value maps to 2^47 unsigned
    assign mx = x[OPW-1] ? OPW'(-x) : OPW'(x);
    assign my = y[OPW-1] ? OPW'(-y) : OPW'(y);

    // leading one of the ored magnitudes sets the doubling count
    always_comb
    begin
        msb = '0;
        for (int b = 0; b < OPW; b++)
        begin
            if (orm_reg[b])
            begin
                msb = SHW'(b);
            end
        end
        sh_next = (msb >= SHW'(NORM_MSB)) ? '0 : SHW'(NORM_MSB) - msb;
    end

    assign xs = VW'(x2_reg) <<< sh_reg;
    assign ys = VW'(y2_reg) <<< sh_reg;

    always_comb
    begin
        vec_next       = '0;
        vec_next.valid = v2_reg;
        vec_next.zero  = zero_reg;
        vec_next.tag   = tag2_reg;
        if (xs[VW-1])
        begin
            vec_next.x  = -xs;
            vec_next.y  = -ys;
            vec_next.cx = -cx2_reg;
            vec_next.cy = -cy2_reg;
            vec_next.z  = ys[VW-1] ? -PI_Q24 : PI_Q24;
        end
        else
        begin
            vec_next.x  = xs;
            vec_next.y  = ys;
            vec_next.cx = cx2_reg;
            vec_next.cy = cy2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            vec_reg <= '0;
        end
        else if (en)
        begin
            v1_reg  <= valid;
            v2_reg  <= v1_reg;
            vec_reg <= vec_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg   <= x;
            y1_reg   <= y;
            cx1_reg  <= cx;
            cy1_reg  <= cy;
            tag1_reg <= tag;
            orm_reg  <= mx | my;
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            cx2_reg  <= cx1_reg;
            cy2_reg  <= cy1_reg;
            tag2_reg <= tag1_reg;
            sh_reg   <= sh_next;
            zero_reg <= (orm_reg == '0);
        end
    end

    assign vec = vec_reg;

endmodule

FILE: hdl/stl_cordic.sv
// vectoring cordic, one registered micro-rotation per stage
`timescale 1ns / 1ps
module stl_cordic
    import stl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  vec_t vin,
    output vec_t vout
);

    vec_t st_reg [NITER];

    for (genvar gi = 0; gi < NITER; gi++)
    begin : g_iter
        vec_t src, st_next;

        if (gi == 0)
        begin : g_first
            assign src = vin;
        end
        else
        begin : g_rest
            assign src = st_reg[gi-1];
        end

        always_comb
        begin
            st_next = src;
            if (!src.y[VW-1])
            begin
                st_next.x  = src.x + (src.y >>> gi);
                st_next.y  = src.y - (src.x >>> gi);
                st_next.cx = src.cx + (src.cy >>> gi);
                st_next.cy = src.cy - (src.cx >>> gi);
                st_next.z  = src.z + atan_q24(gi);
            end
            else
            begin
                st_next.x  = src.x - (src.y >>> gi);
                st_next.y  = src.y + (src.x >>> gi);
                st_next.cx = src.cx - (src.cy >>> gi);
                st_next.cy = src.cy + (src.cx >>> gi);
                st_next.z  = src.z - atan_q24(gi);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_reg[gi] <= '0;
            end
            else if (en)
            begin
                st_reg[gi] <= st_next;
            end
        end
    end

    // a zero vector has no direction: angle 0
    always_comb
    begin
        vout = st_reg[NITER-1];
        if (st_reg[NITER-1].zero)
        begin
            vout.z = '0;
        end
    end

endmodule

FILE: hdl/stanley_steering_law.sv
// top level of the stanley steering law pipeline
`timescale 1ns / 1ps
// Stanley path-tracking steering law. Each item carries a segment (two
// waypoints), the vehicle pose and speed; the block returns the segment
// direction, the signed crosstrack error (Q16.16, saturated, positive left of
// travel) and steering = path_angle - heading + atan2(k*error, k_soft + speed)
// in Q5.13. Fully pipelined: one item may enter every cycle while no result
// is held. An accepted item passes the input register, two chained cordic
// pipelines, one stage per micro-rotation, each behind its normalizer, the
// error scaling stages between them and the output register. A held result
// stalls the whole pipeline in place; in_ready is low only then.
// Gain registers are read live, so write them only while the pipeline is empty.
module stanley_steering_law
    import stl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  cfg_addr_t   cfg_addr,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data
);

    // global pipeline advance
    logic en;

    // configuration
    logic [15:0] gain_reg, soft_reg;

    // input stage: segment and offset vectors
    logic               v0_reg;
    logic signed [32:0] ex_reg, ey_reg, dx_reg, dy_reg;
    logic signed [15:0] psi0_reg, spd0_reg;

    // first cordic: path angle and rotated offset
    vec_t                 vec_a_pre, vec_a;
    logic signed [CW-1:0] dxs, dys;

    // error scaling stages
    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic               zero1_reg, zero2_reg;
    logic signed [15:0] ang1_reg, ang2_reg, ang3_reg, ang4_reg;
    logic signed [15:0] psi1_reg, psi2_reg, psi3_reg, psi4_reg;
    logic signed [15:0] spd1_reg, spd2_reg, spd3_reg;
    logic signed [43:0] ph_reg;
    logic [42:0]        pl_reg;
    logic signed [38:0] err2_reg;
    logic signed [31:0] err3_reg, err4_reg;
    logic signed [OPW-1:0] num_reg, den_reg;

    logic signed [ZW-1:0] za_rnd;
    logic signed [43:0]   ph_next;
    logic [42:0]          pl_next;
    logic signed [66:0]   esum;
    logic signed [31:0]   err_sat;
    logic signed [48:0]   num_full;
    logic signed [17:0]   dsum;

    // second cordic: steering correction angle
    vec_t                 vec_b_pre, vec_b;
    logic signed [ZW-1:0] zb_rnd;
    out_item_t            out_next;

    logic      out_valid_reg;
    out_item_t out_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= 16'd256;
            soft_reg <= 16'd256;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_CROSSTRACK_GAIN: gain_reg <= cfg_wr_data;
                REG_SOFTENING_SPEED: soft_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // exact 33-bit differences
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ex_reg   <= 33'(in_data.end_x) - 33'(in_data.start_x);
            ey_reg   <= 33'(in_data.end_y) - 33'(in_data.start_y);
            dx_reg   <= 33'(in_data.vehicle_x) - 33'(in_data.start_x);
            dy_reg   <= 33'(in_data.vehicle_y) - 33'(in_data.start_y);
            psi0_reg <= in_data.vehicle_heading;
            spd0_reg <= in_data.speed;
        end
    end

    // offset gets 8 guard bits
    assign dxs = CW'(dx_reg) <<< 8;
    assign dys = CW'(dy_reg) <<< 8;

    stl_prenorm u_norm_a (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .valid (v0_reg),
        .x     (OPW'(ex_reg)),
        .y     (OPW'(ey_reg)),
        .cx    (dxs),
        .cy    (dys),
        .tag   ({32'h0, psi0_reg, spd0_reg}),
        .vec   (vec_a_pre)
    );

    stl_cordic u_cordic_a (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .vin   (vec_a_pre),
        .vout  (vec_a)
    );

    // round q24 to q13; split the error product into two narrow multiplies
    assign za_rnd  = (vec_a.z + ZW'(1024)) >>> 11;
    assign ph_next = $signed(vec_a.cy[CW-1:23]) * INV_GAIN_Q20;
    assign pl_next = vec_a.cy[22:0] * INV_GAIN_Q20[19:0];

    // recombine and round away 28 fraction bits
    assign esum = (67'(ph_reg) <<< 23) + $signed({24'h0, pl_reg}) + 67'sd134217728;

    // saturate to 32 bits; a zero-length segment has no error
    always_comb
    begin
        if (zero2_reg)
        begin
            err_sat = '0;
        end
        else if (err2_reg > 39'sd2147483647)
        begin
            err_sat = 32'sh7FFFFFFF;
        end
        else if (err2_reg < -39'sd2147483648)
        begin
            err_sat = 32'sh80000000;
        end
        else
        begin
            err_sat = err2_reg[31:0];
        end
    end

    // k*error in q24 and (k_soft + speed) in q24
    assign num_full = err3_reg * $signed({1'b0, gain_reg});
    assign dsum     = $signed({2'b00, soft_reg}) + 18'(spd3_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang1_reg  <= za_rnd[15:0];
            psi1_reg  <= vec_a.tag[31:16];
            spd1_reg  <= vec_a.tag[15:0];
            zero1_reg <= vec_a.zero;
            ph_reg    <= ph_next;
            pl_reg    <= pl_next;

            ang2_reg  <= ang1_reg;
            psi2_reg  <= psi1_reg;
            spd2_reg  <= spd1_reg;
            zero2_reg <= zero1_reg;
            err2_reg  <= esum[66:28];

            ang3_reg  <= ang2_reg;
            psi3_reg  <= psi2_reg;
            spd3_reg  <= spd2_reg;
            err3_reg  <= err_sat;

            ang4_reg  <= ang3_reg;
            psi4_reg  <= psi3_reg;
            err4_reg  <= err3_reg;
            num_reg   <= num_full[OPW-1:0];
            den_reg   <= OPW'($signed({dsum, 16'h0}));
        end
    end

    stl_prenorm u_norm_b (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .valid (v4_reg),
        .x     (den_reg),
        .y     (num_reg),
        .cx    ('0),
        .cy    ('0),
        .tag   ({psi4_reg, ang4_reg, err4_reg}),
        .vec   (vec_b_pre)
    );

    stl_cordic u_cordic_b (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .vin   (vec_b_pre),
        .vout  (vec_b)
    );

    // steering sum always fits 18 bits
    assign zb_rnd = (vec_b.z + ZW'(1024)) >>> 11;

    always_comb
    begin
        out_next.path_angle       = vec_b.tag[47:32];
        out_next.crosstrack_error = vec_b.tag[31:0];
        out_next.steering_angle   = 18'($signed(vec_b.tag[47:32]))
                                  - 18'($signed(vec_b.tag[63:48]))
                                  + zb_rnd[17:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg        <= in_valid;
            v1_reg        <= vec_a.valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= vec_b.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: hdl/stl_checker.sv
// port-level checks of the steering law pipeline, bound to the top level
`timescale 1ns / 1ps
`include "stanley_steering_law_assert.svh"
module stl_checker
    import stl_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    localparam logic signed [17:0] STEER_MAX = 18'sd84240;

    logic signed [17:0] steer;
    logic               steer_in_range;

    assign steer          = out_data.steering_angle;
    assign steer_in_range = (steer <= STEER_MAX) && (steer >= -STEER_MAX);

    // a waiting item holds still
    `STL_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
    // input side stalls exactly when a result waits
    `STL_ASSERT_IMP(a_ready_rule, clk, rst_n, 1'b1, in_ready == (!out_valid || out_ready))
    // steering stays within path angle plus heading plus pi bounds
    `STL_ASSERT_IMP(a_steer_range, clk, rst_n, out_valid, steer_in_range)
    // a full output with no taker keeps the input closed next cycle unless the result is then taken
    `STL_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, !in_ready || out_ready)

endmodule

bind stanley_steering_law stl_checker u_stl_checker (.*);

FILE: sim/stanley_steering_law_tb.sv
// self-checking testbench for the stanley steering law pipeline
`timescale 1ns / 1ps
module stanley_steering_law_tb;
    import stl_pkg::*;

    // settle margin exceeds the pipeline latency
    localparam int SETTLE_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam longint ANG_PI = 64'sd52707179;
    localparam longint INV_K = 64'sd636752;
    localparam longint LIM45 = 64'sd1 << 45;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    cfg_addr_t cfg_addr;
    logic [15:0] cfg_wr_data;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;

    stanley_steering_law DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    // gain copies used by the predictor
    logic [15:0] gain_k;
    logic [15:0] gain_soft;

    in_item_t pose_queue[$];
    out_item_t steer_expected[$];
    int error_count;
    bit sender_hold;
    bit stimulus_done;
    bit long_stall_req;
    bit in_stuck;
    int idle_cycles;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic longint shr_arith(longint v, int s);
        return v >>> s;
    endfunction

    // vectoring cordic: returns q24 angle, rotates companion vector alongside
    function automatic longint vector_atan(longint x, longint y, inout longint cx,
                                           inout longint cy);
        longint z;
        longint xs;
        longint ys;
        longint cxs;
        longint cys;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        while (x < LIM45 && x > -LIM45 && y < LIM45 && y > -LIM45)
        begin
            x = x * 2;
            y = y * 2;
        end
        // pre-rotation by pi for the left half plane
        if (x < 0)
        begin
            z = (y >= 0) ? ANG_PI : -ANG_PI;
            x = -x;
            y = -y;
            cx = -cx;
            cy = -cy;
        end
        for (int i = 0; i < NITER; i++)
        begin
            xs = shr_arith(x, i);
            ys = shr_arith(y, i);
            cxs = shr_arith(cx, i);
            cys = shr_arith(cy, i);
            if (y >= 0)
            begin
                x += ys; y -= xs; cx += cys; cy -= cxs;
                z += longint'(atan_q24(i));
            end
            else
            begin
                x -= ys; y += xs; cx -= cys; cy += cxs;
                z -= longint'(atan_q24(i));
            end
        end
        return z;
    endfunction

    function automatic out_item_t steer_law(in_item_t p);
        longint ex;
        longint ey;
        longint dx;
        longint dy;
        longint ang;
        longint err;
        longint num;
        longint den;
        longint d1;
        longint d2;
        longint steer;
        out_item_t r;
        ex = longint'(p.end_x) - longint'(p.start_x);
        ey = longint'(p.end_y) - longint'(p.start_y);
        dx = (longint'(p.vehicle_x) - longint'(p.start_x)) * 256;
        dy = (longint'(p.vehicle_y) - longint'(p.start_y)) * 256;
        ang = 0;
        err = 0;
        d1 = 0;
        d2 = 0;
        // a zero-length segment leaves angle and error at zero
        if (ex != 0 || ey != 0)
        begin
            ang = shr_arith(vector_atan(ex, ey, dx, dy) + 1024, 11);
            err = shr_arith(dy * INV_K + (64'sd1 << 27), 28);
            if (err > 64'sd2147483647)
                err = 64'sd2147483647;
            else if (err < -64'sd2147483648)
                err = -64'sd2147483648;
        end
        num = err * longint'({1'b0, gain_k});
        den = (longint'({1'b0, gain_soft}) + longint'(p.speed)) * 65536;
        steer = ang - longint'(p.vehicle_heading)
                + shr_arith(vector_atan(den, num, d1, d2) + 1024, 11);
        r.steering_angle = steer[17:0];
        r.crosstrack_error = err[31:0];
        r.path_angle = ang[15:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // input acceptance seen at the rising edge
    always @(posedge clk)
    begin
        in_stuck = 1'b0;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                steer_expected.push_back(steer_law(in_data));
                void'(pose_queue.pop_front());
            end
            in_stuck = in_valid && !in_ready;
        end
    end

    // driver: bursts of items with random gaps between them
    int burst_left;
    int gap_left;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_stuck)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pose_queue.size() > 0 && !sender_hold)
                begin
                    in_valid <= 1'b1;
                    in_data <= pose_queue[0];
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
                        gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern plus one long hold-off on request
    int stall_phase;
    int long_left;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            stall_phase++;
            if (long_stall_req && long_left == 0)
            begin
                long_left = 150;
                long_stall_req = 0;
            end
            if (long_left > 0)
            begin
                long_left--;
                out_ready <= 1'b0;
            end
            else if ((stall_phase / 64) % 2 == 0)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor: compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (steer_expected.size() == 0)
            begin
                $display("unexpected result item");
                error_count++;
            end
            else
            begin
                want = steer_expected.pop_front();
                if (out_data.steering_angle !== want.steering_angle)
                    report_mismatch("steering_angle", out_data.steering_angle,
                                    want.steering_angle);
                if (out_data.crosstrack_error !== want.crosstrack_error)
                    report_mismatch("crosstrack_error", out_data.crosstrack_error,
                                    want.crosstrack_error);
                if (out_data.path_angle !== want.path_angle)
                    report_mismatch("path_angle", out_data.path_angle, want.path_angle);
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
        endcase
    endfunction

    function automatic in_item_t rand_pose();
        in_item_t p;
        p.start_x = rand_coord();
        p.start_y = rand_coord();
        p.end_x = rand_coord();
        p.end_y = rand_coord();
        p.vehicle_x = rand_coord();
        p.vehicle_y = rand_coord();
        case ($urandom_range(0, 7))
            0: p.end_x = p.start_x;   // vertical segment
            1: p.end_y = p.start_y;   // horizontal segment
            2: begin p.end_x = p.start_x; p.end_y = p.start_y; end
            default: ;
        endcase
        p.vehicle_heading = 16'($urandom());
        p.speed = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 8000));
        return p;
    endfunction

    task automatic add_pose(logic signed [31:0] sx, logic signed [31:0] sy,
                            logic signed [31:0] ex, logic signed [31:0] ey,
                            logic signed [31:0] vx, logic signed [31:0] vy,
                            logic signed [15:0] hd, logic signed [15:0] sp);
        in_item_t p;
        p = '{sx, sy, ex, ey, vx, vy, hd, sp};
        pose_queue.push_back(p);
    endtask

    task automatic wait_drained();
        while (pose_queue.size() > 0 || in_valid || steer_expected.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_gain(cfg_addr_t idx, logic [15:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_CROSSTRACK_GAIN)
            gain_k = val;
        else
            gain_soft = val;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_CROSSTRACK_GAIN;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        gain_k = 16'd256;
        gain_soft = 16'd256;
        error_count = 0;
        sender_hold = 0;
        long_stall_req = 0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        long_left = 0;
        idle_cycles = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, zero-length segment, axis segments, left half plane
        add_pose(0, 0, 0, 0, 32'sh00010000, 32'sh00010000, 0, 0);
        add_pose(0, 0, 32'sh00010000, 0, 0, 32'sh00010000, 0, 16'sh0100);
        add_pose(0, 0, 0, 32'sh00010000, 32'sh00010000, 0, 16'sh1000, 16'sh0200);
        add_pose(0, 0, -32'sh00010000, 0, 0, -32'sh00010000, 0, 0);
        add_pose(0, 0, -32'sh00010000, 32'sh1, 0, 0, 0, 0);
        add_pose(0, 0, -32'sh00010000, -32'sh1, 0, 0, 0, 0);
        add_pose(0, 0, 0, -32'sh00010000, 0, 0, 16'sh7fff, 16'sh7fff);
        add_pose(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                 32'sh80000000, 32'sh7fffffff, 16'sh8000, 16'sh8000);
        add_pose(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                 32'sh7fffffff, 32'sh7fffffff, 16'sh7fff, 16'sh8000);
        add_pose(0, 0, 32'sh1, 0, 32'sh80000000, 32'sh7fffffff, 0, -16'sh0100);
        add_pose(0, 0, 32'sh1, 0, 32'sh7fffffff, 32'sh80000000, 0, 16'shff00);
        add_pose(32'sh7fffffff, 0, 32'sh7fffffff, 0, 0, 0, 16'sh1234, -16'sh0100);
        add_pose(5, 5, 5, 5, 5, 5, 0, 0);
        wait_drained();

        // every register with extremes, and ignored-free settings
        write_gain(REG_CROSSTRACK_GAIN, 16'hffff);
        write_gain(REG_SOFTENING_SPEED, 16'h0000);
        add_pose(0, 0, 32'sh00010000, 0, 0, 32'sh00010000, 0, 0);
        add_pose(0, 0, 32'sh00010000, 0, 0, -32'sh00010000, 0, 16'sh8000);
        add_pose(0, 0, 32'sh00010000, 0, 0, 0, 0, 0);
        for (int i = 0; i < 60; i++)
            pose_queue.push_back(rand_pose());
        wait_drained();

        write_gain(REG_CROSSTRACK_GAIN, 16'h0000);
        write_gain(REG_SOFTENING_SPEED, 16'hffff);
        for (int i = 0; i < 60; i++)
            pose_queue.push_back(rand_pose());
        wait_drained();

        // long receiver hold-off while the sender keeps offering items
        write_gain(REG_CROSSTRACK_GAIN, 16'd256);
        write_gain(REG_SOFTENING_SPEED, 16'd256);
        long_stall_req = 1;
        for (int i = 0; i < 120; i++)
            pose_queue.push_back(rand_pose());
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_gain(REG_CROSSTRACK_GAIN, 16'($urandom()));
            write_gain(REG_SOFTENING_SPEED, 16'($urandom()));
            for (int i = 0; i < 50; i++)
                pose_queue.push_back(rand_pose());
            wait_drained();
        end

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: stanley_steering_law.f
+incdir+hdl
hdl/stl_pkg.sv
hdl/stl_prenorm.sv
hdl/stl_cordic.sv
hdl/stanley_steering_law.sv
hdl/stl_checker.sv
sim/stanley_steering_law_tb.sv
